FILE: design/ltbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ltbm_pkg;

   // register map
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VALIDATION  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POINT0      = 3'd3;
   localparam int unsigned NUM_POINT_REGS = 5;

   // reset values
   localparam logic [7:0]  THRESHOLD_RESET   = 8'd10;
   localparam logic [7:0]  VALIDATION_RESET  = 8'd2;
   localparam logic [2:0]  POINT_COUNT_RESET = 3'd2;
   localparam logic [31:0] POINT1_RESET      = 32'hFFFF_FFFF;
   localparam logic [31:0] POINT_RESET       = 32'h0000_0000;
   localparam logic [15:0] LEVEL_RESET       = 16'hFFFF;

   // divider: quotient is known to fit in 16 bits
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned DIV_CNT_W = 4;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_SCAN  = 6'b000100,
      S_MUL   = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_nonzero;
   } div_status_type;

endpackage

`default_nettype wire

FILE: design/light_to_brightness_mapper.sv
// Ambient light to backlight brightness mapper.
// Input: req_valid/req_ready carry one 16-bit light sample per transfer.
// Output: rsp_valid/rsp_ready carry one 16-bit brightness per accepted
// level change; samples that are within the threshold of the current
// level, or not yet confirmed, produce no output transfer.
// The csr_ port writes threshold, validation count, point count and up to
// five (x,y) breakpoints; write only while the block is idle.
// Flow: a sample that produces no output is accepted, then checked.
// A confirmed change runs the breakpoint scan, the multiply and the slope
// division: the breakpoint scan reads one point per cycle and the slope
// division runs on a 16-step restoring divider. Samples whose value
// falls outside the curve skip the multiply and divide.
// req_ready is high only in the idle state. A finished brightness sits in
// the output register; the next sample is accepted while it waits, and that
// sample's result is held until the output register is free.
// Reset: level 65535, confirm count 0, registers at their reset values,
// no output pending.
`timescale 1ns / 1ps
`default_nettype none

module light_to_brightness_mapper import ltbm_pkg::*; #(
   parameter int unsigned MAX_POINTS = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [15:0]           req_sample,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [15:0]                rsp_brightness,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
   localparam int unsigned STORED = (MAX_POINTS < NUM_POINT_REGS) ? MAX_POINTS
                                                                  : NUM_POINT_REGS;

   state_type   state_ff, state_in;
   logic [15:0] sample_ff;
   logic [15:0] level_ff, level_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  thr_ff;
   logic [7:0]  vcnt_ff;
   logic [2:0]  pcnt_ff;
   logic [31:0] pnt_ff [STORED];

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [15:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [15:0] seg_x1_ff, seg_x1_in, seg_y1_ff, seg_y1_in;
   logic [15:0] res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_brightness_ff, rsp_brightness_in;

   logic [31:0]      cur_pnt;
   logic [15:0]      cx, cy, lo_x, lo_y, fb_res;
   logic [15:0]      abs_diff;
   logic             is_change, confirmed, seg_match;
   logic [IDX_W-1:0] last_idx;
   logic             seg_neg;
   logic [15:0]      seg_mag, seg_dist, seg_dx;
   logic [31:0]      mul_prod;
   logic             div_start;
   logic [15:0]      div_quo;
   div_status_type   div_st;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THRESHOLD_RESET;
         vcnt_ff <= VALIDATION_RESET;
         pcnt_ff <= POINT_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_THRESHOLD:   thr_ff  <= csr_wdata[7:0];
            REG_VALIDATION:  vcnt_ff <= csr_wdata[7:0];
            REG_POINT_COUNT: pcnt_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < STORED; k++) begin : g_pnt
      always_ff @(posedge clock) begin
         if (reset) begin
            pnt_ff[k] <= (k == 1) ? POINT1_RESET : POINT_RESET;
         end else if (csr_wr_en && csr_index == CSR_IDX_W'(32'(REG_POINT0) + k)) begin
            pnt_ff[k] <= csr_wdata;
         end
      end
   end

   // breakpoint read mux; points past the writable ones read as zero
   always_comb begin
      cur_pnt = '0;
      for (int k = 0; k < STORED; k++) begin
         if (idx_ff == IDX_W'(k)) cur_pnt = pnt_ff[k];
      end
   end

   // effective last point index, point count clamped to 1..MAX_POINTS
   always_comb begin
      if (pcnt_ff == 3'd0) begin
         last_idx = '0;
      end else if (32'(pcnt_ff) > 32'(MAX_POINTS)) begin
         last_idx = IDX_W'(MAX_POINTS - 1);
      end else begin
         last_idx = IDX_W'(32'(pcnt_ff) - 32'd1);
      end
   end

   // change test
   assign abs_diff  = (sample_ff > level_ff) ? sample_ff - level_ff : level_ff - sample_ff;
   assign is_change = abs_diff > {8'h00, thr_ff};
   assign confirmed = count_ff >= vcnt_ff;

   // segment scan terms
   assign cx        = cur_pnt[31:16];
   assign cy        = cur_pnt[15:0];
   assign lo_x      = (idx_ff == '0) ? cx : first_x_ff;
   assign lo_y      = (idx_ff == '0) ? cy : first_y_ff;
   assign fb_res    = (sample_ff <= lo_x) ? lo_y : ((sample_ff > cx) ? cy : 16'h0000);
   assign seg_match = (idx_ff != '0) && (prev_x_ff < sample_ff) && (sample_ff <= cx);

   // interpolation operands, sign-magnitude slope
   assign seg_neg  = seg_y1_ff < prev_y_ff;
   assign seg_mag  = seg_neg ? prev_y_ff - seg_y1_ff : seg_y1_ff - prev_y_ff;
   assign seg_dist = sample_ff - prev_x_ff;
   assign seg_dx   = seg_x1_ff - prev_x_ff;
   assign mul_prod = 32'(seg_mag) * 32'(seg_dist);
   assign div_start = (state_ff == S_MUL);

   ltbm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_prod),
      .divisor  (seg_dx),
      .quotient (div_quo),
      .status   (div_st)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      level_in   = level_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      seg_x1_in  = seg_x1_ff;
      seg_y1_in  = seg_y1_ff;
      res_in     = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!is_change) begin
               state_in = S_IDLE;
            end else if (!confirmed) begin
               count_in = count_ff + 8'd1;
               state_in = S_IDLE;
            end else begin
               level_in = sample_ff;
               count_in = '0;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == '0) begin
               first_x_in = cx;
               first_y_in = cy;
            end
            if (seg_match) begin
               seg_x1_in = cx;
               seg_y1_in = cy;
               state_in  = S_MUL;
            end else if (idx_ff == last_idx) begin
               res_in   = fb_res;
               state_in = S_DONE;
            end else begin
               prev_x_in = cx;
               prev_y_in = cy;
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_st.done) begin
               // floor: a negative slope rounds the magnitude up
               res_in = seg_neg ? prev_y_ff - div_quo - {15'h0000, div_st.rem_nonzero}
                                : prev_y_ff + div_quo;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_brightness_in = rsp_brightness_ff;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in      = 1'b1;
         rsp_brightness_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= LEVEL_RESET;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) sample_ff <= req_sample;
      prev_x_ff         <= prev_x_in;
      prev_y_ff         <= prev_y_in;
      first_x_ff        <= first_x_in;
      first_y_ff        <= first_y_in;
      seg_x1_ff         <= seg_x1_in;
      seg_y1_ff         <= seg_y1_in;
      res_ff            <= res_in;
      rsp_brightness_ff <= rsp_brightness_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_brightness = rsp_brightness_ff;

   // checks
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_CHECK)
      else $error("transfer accepted but no change check followed");

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_st.busy)
      else $error("divider busy while accepting samples");

   a_done_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> level_ff == sample_ff && count_ff == 8'd0)
      else $error("result pending without level update");

   a_seg_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> prev_x_ff < sample_ff && sample_ff <= seg_x1_ff)
      else $error("interpolating outside the selected segment");

endmodule

`default_nettype wire

FILE: design/ltbm_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees
// dividend[31:16] < divisor, so the quotient fits in 16 bits.
module ltbm_div import ltbm_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [31:0]    dividend,
   input  wire logic [15:0]    divisor,
   output logic [15:0]         quotient,
   output div_status_type      status
);

   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          quo_ff, quo_in;
   logic [15:0]          dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [16:0] trial;
   logic [17:0] diff;
   logic        fits;

   // one shift/subtract step
   always_comb begin
      trial  = {rem_ff, quo_ff[15]};
      diff   = {1'b0, trial} - {2'b00, dvs_ff};
      fits   = ~diff[17];
      rem_in = fits ? diff[15:0] : trial[15:0];
      quo_in = {quo_ff[14:0], fits};
   end

   // step control
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[31:16];
         quo_ff <= dividend[15:0];
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient           = quo_ff;
   assign status.busy        = busy_ff;
   assign status.done        = done_ff;
   assign status.rem_nonzero = (rem_ff != 16'h0000);

endmodule

`default_nettype wire
